/* rtl/pps_pkg.sv */
// shared types, constants and codes of the packet protocol stats parser
package pps_pkg;

  localparam int DEF_IFACE_COUNT = 256;
  localparam int DEF_LENGTH_BITS = 16;

  localparam int DRAW_W = 32;
  localparam int MOD_W = 16;
  localparam int CNT_W = 64;
  localparam int MOD_STEPS = 2;
  localparam int MOD_ITERS = DRAW_W / MOD_STEPS;
  localparam int MOD_CNT_W = $clog2(MOD_ITERS);

  localparam logic [MOD_W-1:0] MODULUS_RESET = 16'd100;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam int MIN_IP_LEN = 34;
  localparam int TCP_LEN = 54;
  localparam int UDP_LEN = 42;

  localparam int POS_ETHER_HI = 12;
  localparam int POS_ETHER_LO = 13;
  localparam int POS_PROTO = 23;
  localparam int POS_SRC_FIRST = 26;
  localparam int POS_SRC_LAST = 29;
  localparam int POS_DST_FIRST = 30;
  localparam int POS_DST_LAST = 33;
  localparam int POS_PORT_FIRST = 34;
  localparam int POS_PORT_LAST = 37;

  typedef enum logic [1:0] {
    MOD_IDLE,
    MOD_RUN,
    MOD_DONE
  } mod_state_t;

  typedef struct packed {
    logic [15:0] ether_kind;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
  } frame_t;

  typedef struct packed {
    logic [CNT_W-1:0] pkts;
    logic [CNT_W-1:0] bytes;
    logic [CNT_W-1:0] tcp;
    logic [CNT_W-1:0] udp;
    logic [CNT_W-1:0] icmp;
  } counters_t;

  typedef struct packed {
    logic             rd_en;
    logic             upd;
    logic [CNT_W-1:0] len;
    logic             is_tcp;
    logic             is_udp;
    logic             is_icmp;
  } cnt_ctl_t;

  typedef struct packed {
    logic busy;
    logic fin;
    logic rem_zero;
  } mod_stat_t;

  typedef struct packed {
    logic        result_kind;
    logic [63:0] stamp;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [63:0] byte_value;
    logic [7:0]  proto_num;
    logic [63:0] frame_count;
    logic [63:0] tcp_count;
    logic [63:0] udp_count;
    logic [63:0] icmp_count;
  } out_item_t;

endpackage

/* rtl/pps_if.sv */
// channel interfaces of the packet protocol stats parser
interface pps_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  pkt_byte;
  logic        last_byte;
  logic [7:0]  iface;
  logic [31:0] draw;
  logic [63:0] now_ns;

  modport source (
    output valid, cmd, pkt_byte, last_byte, iface, draw, now_ns,
    input  ready
  );
  modport sink (
    input  valid, cmd, pkt_byte, last_byte, iface, draw, now_ns,
    output ready
  );
endinterface

interface pps_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] stamp;
  logic [31:0] source_addr;
  logic [31:0] dest_addr;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [63:0] byte_value;
  logic [7:0]  proto_num;
  logic [63:0] frame_count;
  logic [63:0] tcp_count;
  logic [63:0] udp_count;
  logic [63:0] icmp_count;

  modport source (
    output valid, result_kind, stamp, source_addr, dest_addr, source_port, dest_port,
    output byte_value, proto_num, frame_count, tcp_count, udp_count, icmp_count,
    input  ready
  );
  modport sink (
    input  valid, result_kind, stamp, source_addr, dest_addr, source_port, dest_port,
    input  byte_value, proto_num, frame_count, tcp_count, udp_count, icmp_count,
    output ready
  );
endinterface

interface pps_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_modulus;

  modport source (
    output valid, sample_modulus,
    input  ready
  );
  modport sink (
    input  valid, sample_modulus,
    output ready
  );
endinterface

/* rtl/pps_frame_parser.sv */
// per-frame header capture and byte offset tracking
module pps_frame_parser #(
  parameter int LENGTH_BITS = pps_pkg::DEF_LENGTH_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_en,
  input  logic [7:0]             pkt_byte,
  input  logic                   last_byte,
  output logic [LENGTH_BITS-1:0] len_nxt,
  output pps_pkg::frame_t        frame_nxt
);
  import pps_pkg::*;

  logic [LENGTH_BITS-1:0] offset_r;
  frame_t                 frame_r;

  always_comb begin
    frame_nxt = frame_r;
    if (offset_r == LENGTH_BITS'(POS_ETHER_HI) || offset_r == LENGTH_BITS'(POS_ETHER_LO)) begin
      frame_nxt.ether_kind = {frame_r.ether_kind[7:0], pkt_byte};
    end else if (offset_r == LENGTH_BITS'(POS_PROTO)) begin
      frame_nxt.proto = pkt_byte;
    end else if (offset_r >= LENGTH_BITS'(POS_SRC_FIRST) &&
                 offset_r <= LENGTH_BITS'(POS_SRC_LAST)) begin
      frame_nxt.src_addr = {frame_r.src_addr[23:0], pkt_byte};
    end else if (offset_r >= LENGTH_BITS'(POS_DST_FIRST) &&
                 offset_r <= LENGTH_BITS'(POS_DST_LAST)) begin
      frame_nxt.dst_addr = {frame_r.dst_addr[23:0], pkt_byte};
    end else if (offset_r >= LENGTH_BITS'(POS_PORT_FIRST) &&
                 offset_r <= LENGTH_BITS'(POS_PORT_LAST)) begin
      frame_nxt.ports = {frame_r.ports[23:0], pkt_byte};
    end
    len_nxt = (offset_r == {LENGTH_BITS{1'b1}}) ? offset_r : offset_r + LENGTH_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      frame_r  <= '0;
    end else if (byte_en) begin
      if (last_byte) begin
        offset_r <= '0;
        frame_r  <= '0;
      end else begin
        offset_r <= len_nxt;
        frame_r  <= frame_nxt;
      end
    end
  end

endmodule

/* rtl/pps_mod_unit.sv */
// iterative remainder unit for the sampling decision, two bits per cycle
module pps_mod_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pps_pkg::DRAW_W-1:0]     dividend,
  input  logic [pps_pkg::MOD_W-1:0]      divisor,
  input  logic                           ack,
  output pps_pkg::mod_stat_t             stat
);
  import pps_pkg::*;

  mod_state_t           state_r, state_nxt;
  logic [DRAW_W-1:0]    dvd_r, dvd_nxt;
  logic [MOD_W-1:0]     rem_r, rem_nxt;
  logic [MOD_W-1:0]     dsr_r;
  logic [MOD_CNT_W-1:0] cnt_r;

  always_comb begin
    logic [MOD_W:0] trial;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    trial = '0;
    for (int i = 0; i < MOD_STEPS; i++) begin
      trial = {rem_nxt, dvd_nxt[DRAW_W-1]};
      if (trial >= {1'b0, dsr_r}) begin
        trial = trial - {1'b0, dsr_r};
      end
      rem_nxt = trial[MOD_W-1:0];
      dvd_nxt = {dvd_nxt[DRAW_W-2:0], 1'b0};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MOD_IDLE: begin
        if (start) state_nxt = MOD_RUN;
      end
      MOD_RUN: begin
        if (cnt_r == MOD_CNT_W'(MOD_ITERS - 1)) state_nxt = MOD_DONE;
      end
      MOD_DONE: begin
        if (ack) state_nxt = MOD_IDLE;
      end
      default: state_nxt = MOD_IDLE;
    endcase
    stat.busy     = (state_r != MOD_IDLE);
    stat.fin      = (state_r == MOD_DONE);
    stat.rem_zero = (rem_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MOD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == MOD_IDLE && start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
      cnt_r <= '0;
    end else if (state_r == MOD_RUN) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + MOD_CNT_W'(1);
    end
  end

endmodule

/* rtl/pps_count_mem.sv */
// per-interface counter memory with read-modify-write and clearing pass
module pps_count_mem #(
  parameter int IFACE_COUNT = pps_pkg::DEF_IFACE_COUNT,
  parameter int IDX_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pps_pkg::cnt_ctl_t    ctl,
  input  logic [IDX_W-1:0]     idx,
  output logic                 clearing,
  output pps_pkg::counters_t   rd_data
);
  import pps_pkg::*;

  counters_t        cnt_mem_r [IFACE_COUNT];
  counters_t        rd_data_r;
  counters_t        upd_val;
  logic             clr_active_r;
  logic [IDX_W-1:0] clr_idx_r;
  logic             upd_r;
  logic [IDX_W-1:0] upd_idx_r;
  logic [CNT_W-1:0] upd_len_r;
  logic             upd_tcp_r;
  logic             upd_udp_r;
  logic             upd_icmp_r;

  always_comb begin
    upd_val.pkts  = rd_data_r.pkts + CNT_W'(1);
    upd_val.bytes = rd_data_r.bytes + upd_len_r;
    upd_val.tcp   = rd_data_r.tcp + CNT_W'(upd_tcp_r);
    upd_val.udp   = rd_data_r.udp + CNT_W'(upd_udp_r);
    upd_val.icmp  = rd_data_r.icmp + CNT_W'(upd_icmp_r);
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      cnt_mem_r[clr_idx_r] <= '0;
    end else if (upd_r) begin
      cnt_mem_r[upd_idx_r] <= upd_val;
    end
    if (ctl.rd_en) begin
      rd_data_r <= cnt_mem_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      upd_r        <= 1'b0;
    end else begin
      if (clr_active_r) begin
        if (clr_idx_r == IDX_W'(IFACE_COUNT - 1)) begin
          clr_active_r <= 1'b0;
        end else begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
        end
      end
      upd_r <= ctl.upd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      upd_idx_r  <= idx;
      upd_len_r  <= ctl.len;
      upd_tcp_r  <= ctl.is_tcp;
      upd_udp_r  <= ctl.is_udp;
      upd_icmp_r <= ctl.is_icmp;
    end
  end

  assign clearing = clr_active_r;
  assign rd_data  = rd_data_r;

endmodule

/* rtl/packet_protocol_stats_parser.sv */
// top level of the per-interface ipv4 protocol counter block
// Takes one frame byte or read command per cycle. A counted frame (IPv4, at
// least 34 bytes, interface in range) updates its interface's counters in a
// one-port-per-cycle counter memory by read-modify-write and starts a remainder
// unit for the sampling decision (two bits per step, then a hand-over of its
// answer); while that unit is busy, and longer while a sample event waits at the
// output, read commands and last bytes of frames wait, other frame bytes still
// flow at one per cycle. A read command is held in s1_rd_r while the counter
// memory registers its data, then the readout is registered in out_r. After
// reset the counter memory is cleared one entry per cycle, and no item is taken
// until that pass ends; the sampling modulus can be written at any time.
module packet_protocol_stats_parser #(
  parameter int IFACE_COUNT = pps_pkg::DEF_IFACE_COUNT,
  parameter int LENGTH_BITS = pps_pkg::DEF_LENGTH_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch,
  pps_cfg_if.sink   cfg_ch
);
  import pps_pkg::*;

  localparam int IDX_W = (IFACE_COUNT > 1) ? $clog2(IFACE_COUNT) : 1;

  logic [MOD_W-1:0]       modulus_r;
  logic [31:0]            iface_ext;
  logic                   in_range;
  logic [IDX_W-1:0]       idx;
  logic                   is_read;
  logic                   accept;
  logic                   byte_en;
  logic                   counted;
  logic [LENGTH_BITS-1:0] len_nxt;
  frame_t                 frame_nxt;
  cnt_ctl_t               cm_ctl;
  logic                   clearing;
  counters_t              cm_rd_data;
  mod_stat_t              mod_stat;
  logic                   mod_ack;
  logic                   ports_ok;
  logic                   out_free;
  logic                   s1_rd_r;
  logic                   s1_in_range_r;
  out_item_t              ev_r;
  out_item_t              readout;
  out_item_t              out_r;
  logic                   out_valid_r;

  assign iface_ext = 32'(in_ch.iface);
  assign in_range  = iface_ext < 32'(IFACE_COUNT);
  assign idx       = iface_ext[IDX_W-1:0];
  assign is_read   = (in_ch.cmd == CMD_READ);
  assign out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready = !clearing && !(s1_rd_r && !out_free) &&
                       (!mod_stat.busy || (!is_read && !in_ch.last_byte));
  assign accept  = in_ch.valid && in_ch.ready;
  assign byte_en = accept && !is_read;
  assign counted = byte_en && in_ch.last_byte && in_range &&
                   len_nxt >= LENGTH_BITS'(MIN_IP_LEN) &&
                   frame_nxt.ether_kind == ETHERTYPE_IPV4;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      modulus_r <= cfg_ch.sample_modulus;
    end
  end

  pps_frame_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (byte_en),
    .pkt_byte (in_ch.pkt_byte),
    .last_byte(in_ch.last_byte),
    .len_nxt  (len_nxt),
    .frame_nxt(frame_nxt)
  );

  always_comb begin
    cm_ctl.rd_en   = (accept && is_read && in_range) || counted;
    cm_ctl.upd     = counted;
    cm_ctl.len     = CNT_W'(len_nxt);
    cm_ctl.is_tcp  = (frame_nxt.proto == PROTO_TCP);
    cm_ctl.is_udp  = (frame_nxt.proto == PROTO_UDP);
    cm_ctl.is_icmp = (frame_nxt.proto == PROTO_ICMP);
  end

  pps_count_mem #(
    .IFACE_COUNT(IFACE_COUNT),
    .IDX_W      (IDX_W)
  ) u_count_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cm_ctl),
    .idx     (idx),
    .clearing(clearing),
    .rd_data (cm_rd_data)
  );

  assign mod_ack = mod_stat.fin && !s1_rd_r && (out_free || !mod_stat.rem_zero);

  pps_mod_unit u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (counted),
    .dividend(in_ch.draw),
    .divisor ((modulus_r == '0) ? MOD_W'(1) : modulus_r),
    .ack     (mod_ack),
    .stat    (mod_stat)
  );

  assign ports_ok = (cm_ctl.is_tcp && len_nxt >= LENGTH_BITS'(TCP_LEN)) ||
                    (cm_ctl.is_udp && len_nxt >= LENGTH_BITS'(UDP_LEN));

  // event fields held while the sampling decision is worked out
  always_ff @(posedge clk) begin
    if (counted) begin
      ev_r.result_kind <= KIND_EVENT;
      ev_r.stamp       <= in_ch.now_ns;
      ev_r.source_addr <= frame_nxt.src_addr;
      ev_r.dest_addr   <= frame_nxt.dst_addr;
      ev_r.source_port <= ports_ok ? frame_nxt.ports[31:16] : 16'd0;
      ev_r.dest_port   <= ports_ok ? frame_nxt.ports[15:0] : 16'd0;
      ev_r.byte_value  <= 64'(len_nxt);
      ev_r.proto_num   <= frame_nxt.proto;
      ev_r.frame_count <= '0;
      ev_r.tcp_count   <= '0;
      ev_r.udp_count   <= '0;
      ev_r.icmp_count  <= '0;
    end
  end

  always_comb begin
    readout             = '0;
    readout.result_kind = KIND_READOUT;
    if (s1_in_range_r) begin
      readout.byte_value  = cm_rd_data.bytes;
      readout.frame_count = cm_rd_data.pkts;
      readout.tcp_count   = cm_rd_data.tcp;
      readout.udp_count   = cm_rd_data.udp;
      readout.icmp_count  = cm_rd_data.icmp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_rd_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && is_read) begin
        s1_rd_r <= 1'b1;
      end else if (s1_rd_r && out_free) begin
        s1_rd_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_rd_r || (mod_ack && mod_stat.rem_zero);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      s1_in_range_r <= in_range;
    end
    if (out_free) begin
      if (s1_rd_r) begin
        out_r <= readout;
      end else if (mod_ack && mod_stat.rem_zero) begin
        out_r <= ev_r;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_r.result_kind;
  assign out_ch.stamp       = out_r.stamp;
  assign out_ch.source_addr = out_r.source_addr;
  assign out_ch.dest_addr   = out_r.dest_addr;
  assign out_ch.source_port = out_r.source_port;
  assign out_ch.dest_port   = out_r.dest_port;
  assign out_ch.byte_value  = out_r.byte_value;
  assign out_ch.proto_num   = out_r.proto_num;
  assign out_ch.frame_count = out_r.frame_count;
  assign out_ch.tcp_count   = out_r.tcp_count;
  assign out_ch.udp_count   = out_r.udp_count;
  assign out_ch.icmp_count  = out_r.icmp_count;

endmodule

/* rtl/pps_checker.sv */
// port-level assertions of the packet protocol stats parser and their bind
module pps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [63:0] out_stamp,
  input logic [31:0] out_src,
  input logic [15:0] out_sport,
  input logic [15:0] out_dport,
  input logic [7:0]  out_proto,
  input logic [63:0] out_bytes,
  input logic [63:0] out_frames
);
  import pps_pkg::*;

  // clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item taken during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_bytes))
    else $error("result dropped or changed while stalled");

  a_readout_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_READOUT |->
      out_stamp == 64'd0 && out_src == 32'd0 && out_proto == 8'd0)
    else $error("readout carries event fields");

  a_event_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EVENT |->
      out_frames == 64'd0 && out_bytes >= 64'(MIN_IP_LEN))
    else $error("event carries counter fields or short length");

  a_event_ports: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_EVENT && out_proto != PROTO_TCP &&
      out_proto != PROTO_UDP |-> out_sport == 16'd0 && out_dport == 16'd0)
    else $error("ports on a frame that is neither tcp nor udp");

endmodule

bind packet_protocol_stats_parser pps_checker u_pps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_stamp (out_ch.stamp),
  .out_src   (out_ch.source_addr),
  .out_sport (out_ch.source_port),
  .out_dport (out_ch.dest_port),
  .out_proto (out_ch.proto_num),
  .out_bytes (out_ch.byte_value),
  .out_frames(out_ch.frame_count)
);

/* bench/tb.sv */
// testbench of the per-interface ipv4 protocol counter block
`timescale 1ns / 1ps

module tb;
  import pps_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 230;
  localparam logic [7:0] PROTO_OSPF = 8'd89;
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  pkt_byte;
    logic        last_byte;
    logic [7:0]  iface;
    logic [31:0] draw;
    logic [63:0] now_ns;
  } in_item_t;

  class stats_board;
    bit [63:0] pkt_tot [256];
    bit [63:0] byte_tot [256];
    bit [63:0] tcp_tot [256];
    bit [63:0] udp_tot [256];
    bit [63:0] icmp_tot [256];
    bit [15:0] offset;
    bit [15:0] ethertype;
    bit [7:0]  proto;
    bit [31:0] src;
    bit [31:0] dst;
    bit [31:0] ports;
    bit [15:0] modulus;
    out_item_t waiting[$];
    int errors;

    function new();
      foreach (pkt_tot[i]) begin
        pkt_tot[i] = '0;
        byte_tot[i] = '0;
        tcp_tot[i] = '0;
        udp_tot[i] = '0;
        icmp_tot[i] = '0;
      end
      modulus = MODULUS_RESET;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      offset = '0;
      ethertype = '0;
      proto = '0;
      src = '0;
      dst = '0;
      ports = '0;
    endfunction

    function void take_item(in_item_t it);
      out_item_t r;
      bit [31:0] m;
      bit [15:0] len;
      r = '0;
      if (it.cmd == CMD_READ) begin
        r.result_kind = KIND_READOUT;
        r.byte_value = byte_tot[it.iface];
        r.frame_count = pkt_tot[it.iface];
        r.tcp_count = tcp_tot[it.iface];
        r.udp_count = udp_tot[it.iface];
        r.icmp_count = icmp_tot[it.iface];
        waiting.push_back(r);
        return;
      end
      if (offset == POS_ETHER_HI || offset == POS_ETHER_LO) begin
        ethertype = {ethertype[7:0], it.pkt_byte};
      end else if (offset == POS_PROTO) begin
        proto = it.pkt_byte;
      end else if (offset >= POS_SRC_FIRST && offset <= POS_SRC_LAST) begin
        src = {src[23:0], it.pkt_byte};
      end else if (offset >= POS_DST_FIRST && offset <= POS_DST_LAST) begin
        dst = {dst[23:0], it.pkt_byte};
      end else if (offset >= POS_PORT_FIRST && offset <= POS_PORT_LAST) begin
        ports = {ports[23:0], it.pkt_byte};
      end
      if (offset != 16'hFFFF) offset++;
      if (!it.last_byte) return;
      len = offset;
      if (len >= MIN_IP_LEN && ethertype == ETHERTYPE_IPV4) begin
        pkt_tot[it.iface] += 1;
        byte_tot[it.iface] += 64'(len);
        if (proto == PROTO_TCP) tcp_tot[it.iface] += 1;
        else if (proto == PROTO_UDP) udp_tot[it.iface] += 1;
        else if (proto == PROTO_ICMP) icmp_tot[it.iface] += 1;
        m = (modulus == 0) ? 32'd1 : {16'd0, modulus};
        if (it.draw % m == 0) begin
          r.result_kind = KIND_EVENT;
          r.stamp = it.now_ns;
          r.source_addr = src;
          r.dest_addr = dst;
          if ((proto == PROTO_TCP && len >= TCP_LEN) ||
              (proto == PROTO_UDP && len >= UDP_LEN)) begin
            r.source_port = ports[31:16];
            r.dest_port = ports[15:0];
          end
          r.byte_value = 64'(len);
          r.proto_num = proto;
          waiting.push_back(r);
        end
      end
      clear_frame();
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (waiting.size() == 0) begin
        $display("%0t: unexpected result expected none got kind %b", $time,
                 got.result_kind);
        errors++;
        return;
      end
      want = waiting.pop_front();
      check_field("result_kind", want.result_kind, got.result_kind);
      check_field("stamp", want.stamp, got.stamp);
      check_field("source_addr", want.source_addr, got.source_addr);
      check_field("dest_addr", want.dest_addr, got.dest_addr);
      check_field("source_port", want.source_port, got.source_port);
      check_field("dest_port", want.dest_port, got.dest_port);
      check_field("byte_value", want.byte_value, got.byte_value);
      check_field("proto_num", want.proto_num, got.proto_num);
      check_field("frame_count", want.frame_count, got.frame_count);
      check_field("tcp_count", want.tcp_count, got.tcp_count);
      check_field("udp_count", want.udp_count, got.udp_count);
      check_field("icmp_count", want.icmp_count, got.icmp_count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pps_in_if  in_ch();
  pps_out_if out_ch();
  pps_cfg_if cfg_ch();

  stats_board board = new();
  int items_sent = 0;
  int burst_left = 0;

  packet_protocol_stats_parser u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // receiver: stalls come and go in phases
  initial begin
    int hold_left;
    int phase_left;
    bit stalls_on;
    out_ch.ready = 1'b0;
    hold_left = 0;
    phase_left = 50;
    stalls_on = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 7);
      end
      phase_left--;
      if (phase_left == 0) begin
        stalls_on = !stalls_on;
        phase_left = $urandom_range(20, 200);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.result_kind = out_ch.result_kind;
      got.stamp = out_ch.stamp;
      got.source_addr = out_ch.source_addr;
      got.dest_addr = out_ch.dest_addr;
      got.source_port = out_ch.source_port;
      got.dest_port = out_ch.dest_port;
      got.byte_value = out_ch.byte_value;
      got.proto_num = out_ch.proto_num;
      got.frame_count = out_ch.frame_count;
      got.tcp_count = out_ch.tcp_count;
      got.udp_count = out_ch.udp_count;
      got.icmp_count = out_ch.icmp_count;
      board.match_result(got);
    end
  end

  function automatic logic [63:0] rand_stamp();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] pick_iface();
    logic [7:0] pool[5] = '{8'd0, 8'd1, 8'd2, 8'd254, 8'd255};
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return pool[$urandom_range(0, 4)];
  endfunction

  function automatic logic [31:0] pick_draw(bit hit);
    bit [31:0] m;
    m = (board.modulus == 0) ? 32'd1 : {16'd0, board.modulus};
    if (hit) return m * $urandom_range(0, 32'hFFFF_FFFF / m);
    return $urandom;
  endfunction

  // sender: bursts of random length separated by random gaps
  task automatic push_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= it.cmd;
    in_ch.pkt_byte <= it.pkt_byte;
    in_ch.last_byte <= it.last_byte;
    in_ch.iface <= it.iface;
    in_ch.draw <= it.draw;
    in_ch.now_ns <= it.now_ns;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.take_item(it);
    items_sent++;
  endtask

  task automatic send_read(input logic [7:0] ifc);
    in_item_t it;
    it.cmd = CMD_READ;
    it.pkt_byte = 8'($urandom_range(0, 255));
    it.last_byte = 1'($urandom_range(0, 1));
    it.iface = ifc;
    it.draw = $urandom;
    it.now_ns = rand_stamp();
    push_item(it);
  endtask

  task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
                            input logic [7:0] ifc, input logic [31:0] draw,
                            input bit noisy, input bit with_reads);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      if (with_reads && $urandom_range(0, 7) == 0) send_read(pick_iface());
      it.cmd = CMD_FRAME;
      it.pkt_byte = 8'($urandom_range(0, 255));
      if (i == POS_ETHER_HI) it.pkt_byte = etype[15:8];
      if (i == POS_ETHER_LO) it.pkt_byte = etype[7:0];
      if (i == POS_PROTO) it.pkt_byte = proto;
      it.last_byte = (i == len - 1);
      it.iface = (it.last_byte || !noisy) ? ifc : 8'($urandom_range(0, 255));
      it.draw = it.last_byte ? draw : $urandom;
      it.now_ns = rand_stamp();
      push_item(it);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.waiting.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_op();
    int edges[8] = '{33, 34, 37, 38, 41, 42, 53, 54};
    int len;
    logic [7:0] proto;
    logic [15:0] etype;
    case ($urandom_range(0, 9))
      0: send_read(pick_iface());
      1: begin
        etype = $urandom_range(0, 1) ? ETHERTYPE_IPV4 : 16'($urandom);
        send_frame($urandom_range(1, 80), etype, 8'($urandom), 8'($urandom),
                   $urandom, 1'b1, 1'b1);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: proto = PROTO_TCP;
          1: proto = PROTO_UDP;
          2: proto = PROTO_ICMP;
          default: proto = 8'($urandom_range(0, 255));
        endcase
        len = ($urandom_range(0, 3) == 0) ? edges[$urandom_range(0, 7)]
                                          : $urandom_range(34, 90);
        send_frame(len, ETHERTYPE_IPV4, proto, pick_iface(),
                   pick_draw($urandom_range(0, 1) == 1), $urandom_range(0, 5) == 0,
                   $urandom_range(0, 2) == 0);
      end
    endcase
  endtask

  initial begin
    logic [15:0] moduli[5];
    int start;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_FRAME;
    in_ch.pkt_byte = '0;
    in_ch.last_byte = 1'b0;
    in_ch.iface = '0;
    in_ch.draw = '0;
    in_ch.now_ns = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.sample_modulus = MODULUS_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_read(8'd0);
    send_read(8'd255);
    send_frame(TCP_LEN, ETHERTYPE_IPV4, PROTO_TCP, 8'd0, 32'd0, 1'b0, 1'b0);
    send_frame(TCP_LEN - 1, ETHERTYPE_IPV4, PROTO_TCP, 8'd0, 32'd200, 1'b0, 1'b0);
    send_frame(UDP_LEN, ETHERTYPE_IPV4, PROTO_UDP, 8'd255, 32'd100, 1'b0, 1'b0);
    send_frame(UDP_LEN - 1, ETHERTYPE_IPV4, PROTO_UDP, 8'd255, 32'd300, 1'b0, 1'b0);
    send_frame(MIN_IP_LEN, ETHERTYPE_IPV4, PROTO_ICMP, 8'd1, 32'hFFFF_FFA0, 1'b0, 1'b0);
    send_frame(60, ETHERTYPE_IPV4, PROTO_OSPF, 8'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_frame(60, ETHERTYPE_IPV4, PROTO_OSPF, 8'd2, 32'd0, 1'b1, 1'b1);
    send_frame(MIN_IP_LEN - 1, ETHERTYPE_IPV4, PROTO_TCP, 8'd0, 32'd0, 1'b0, 1'b0);
    send_frame(1, ETHERTYPE_IPV4, PROTO_TCP, 8'd0, 32'd0, 1'b0, 1'b0);
    send_frame(60, ETHERTYPE_IPV6, PROTO_TCP, 8'd0, 32'd0, 1'b0, 1'b0);
    send_frame(70, ETHERTYPE_IPV4, PROTO_TCP, 8'd3, 32'd0, 1'b1, 1'b1);
    send_read(8'd0);
    send_read(8'd1);
    send_read(8'd2);
    send_read(8'd3);
    send_read(8'd255);

    moduli = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(2, 400)), 16'd7};
    foreach (moduli[p]) begin
      wait_drained();
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.sample_modulus <= moduli[p];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
      board.modulus = moduli[p];
      @(negedge clk);
      cfg_ch.valid <= 1'b0;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) random_op();
    end

    wait_drained();
    if (board.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
